### rtl/lbc_pkg.sv
// Package for the LRU block cache tag engine: beat types, register indexes, codes.
`timescale 1ns / 1ps

package lbc_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 5;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOTS_IN_USE    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_SIZE_LOG2 = 1'b1;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] SLOTS_IN_USE_RST    = 5'd16;
    localparam logic [CFG_DATA_W-1:0] BLOCK_SIZE_LOG2_RST = 5'd12;

    // Block size limits (log2 of bytes)
    localparam logic [4:0] BLK_LOG2_MIN = 5'd3;
    localparam logic [4:0] BLK_LOG2_MAX = 5'd16;

    // Operation codes
    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_RENAME = 1'b1;

    // Status codes
    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_FILL_FAILED = 1'b1;

    // Request beat
    typedef struct packed {
        logic        func;
        logic [15:0] file_id;
        logic [15:0] new_file_id;
        logic [31:0] offset;
        logic [31:0] request_length;
        logic [16:0] fill_length;
        logic        fill_failed;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic        evicted;
        logic [15:0] block_offset;
        logic [16:0] bytes_to_copy;
        logic        end_of_file;
        logic        status;
        logic [4:0]  renamed_count;
    } out_beat_t;

endpackage

### rtl/lru_block_cache_tags_top.sv
// Tag lookup and LRU replacement engine of a fully associative block cache.
//
// Usage: a request beat on s_* is either a block access (file id, byte
// offset, bytes wanted, fill length and fill status from the backing store)
// or a rename of a file id. Each request gives exactly one result beat on
// m_*: slot hit or filled, offset within the block, bytes to copy, end of
// file, fill status, or the number of entries relabeled by a rename.
// The request is held in the input register and its result in the result
// register; one request is taken every cycle while m_ready does not hold a
// beat back, since all tags are compared in parallel and the tag, length and
// recency registers update in the same cycle the result is registered.
// When m_ready is low the result register holds its beat and the input
// register holds one more; s_ready drops only when both are full.
// Reset (aresetn low, synchronous) empties the cache (no slot filled) and
// sets slots_in_use to 16 and block_size_log2 to 12. Write the cfg_*
// registers only while no request is outstanding.
`timescale 1ns / 1ps

module lru_block_cache_tags_top #(
    parameter int unsigned SLOTS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [lbc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  lbc_pkg::in_beat_t                 s_data,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output lbc_pkg::out_beat_t                m_data
);

    localparam int unsigned IDX_W = $clog2(SLOTS);
    localparam int unsigned CNT_W = $clog2(SLOTS + 1);
    localparam int unsigned LIM_W = (CNT_W > 5) ? CNT_W : 5;

    // Configuration registers
    logic [lbc_pkg::CFG_DATA_W-1:0] slots_in_use_reg;
    logic [lbc_pkg::CFG_DATA_W-1:0] blk_log2_reg;

    // Input and result registers
    lbc_pkg::in_beat_t  in_reg;
    logic               in_valid_reg;
    lbc_pkg::out_beat_t out_reg;
    logic               out_valid_reg;
    lbc_pkg::out_beat_t out_next;

    // Tag store, one register set per slot
    logic [15:0]      file_reg  [SLOTS];
    logic [28:0]      bnum_reg  [SLOTS];
    logic [16:0]      len_reg   [SLOTS];
    logic [IDX_W-1:0] rank_reg  [SLOTS];
    logic [15:0]      file_next [SLOTS];
    logic [28:0]      bnum_next [SLOTS];
    logic [16:0]      len_next  [SLOTS];
    logic [IDX_W-1:0] rank_next [SLOTS];
    logic [CNT_W-1:0] filled_reg;
    logic [CNT_W-1:0] filled_next;

    // Lookup signals
    logic             fire;
    logic [4:0]       lg;
    logic [16:0]      bs;
    logic [28:0]      bnum;
    logic [15:0]      boff;
    logic [LIM_W-1:0] limit;
    logic [SLOTS-1:0] valid_vec;
    logic [SLOTS-1:0] acc_match;
    logic [SLOTS-1:0] ren_match;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] lru_idx;
    logic [IDX_W-1:0] tgt_idx;
    logic [IDX_W-1:0] lru_rank;
    logic             free_slot;
    logic [CNT_W-1:0] old_rank;
    logic [16:0]      fill_len;
    logic [16:0]      len_sel;
    logic [16:0]      copy_raw;
    logic [16:0]      copy_len;
    logic             do_access;
    logic             miss_fail;
    logic             do_update;
    logic             do_rename;

    // Advance the pipeline when the result register is free or being drained
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Clamp the configuration values
    always_comb begin
        if (blk_log2_reg < lbc_pkg::BLK_LOG2_MIN) begin
            lg = lbc_pkg::BLK_LOG2_MIN;
        end else if (blk_log2_reg > lbc_pkg::BLK_LOG2_MAX) begin
            lg = lbc_pkg::BLK_LOG2_MAX;
        end else begin
            lg = blk_log2_reg;
        end
        if (slots_in_use_reg == '0) begin
            limit = LIM_W'(1);
        end else if (LIM_W'(slots_in_use_reg) > LIM_W'(SLOTS)) begin
            limit = LIM_W'(SLOTS);
        end else begin
            limit = LIM_W'(slots_in_use_reg);
        end
    end

    // Split the offset into block number and offset within the block
    assign bs       = 17'd1 << lg;
    assign bnum     = 29'(in_reg.offset >> lg);
    assign boff     = 16'(in_reg.offset & (32'(bs) - 32'd1));
    assign fill_len = (in_reg.fill_length < bs) ? in_reg.fill_length : bs;
    assign lru_rank = IDX_W'(filled_reg - CNT_W'(1));
    assign free_slot = LIM_W'(filled_reg) < limit;

    // Compare all tags in parallel
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            valid_vec[i] = filled_reg > CNT_W'(i);
            ren_match[i] = valid_vec[i] && (file_reg[i] == in_reg.file_id);
            acc_match[i] = ren_match[i] && (bnum_reg[i] == bnum)
                           && (17'(boff) < len_reg[i]);
        end
    end

    // Pick the lowest matching slot and the least recently used slot
    always_comb begin
        hit_idx = '0;
        lru_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (acc_match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (valid_vec[i] && (rank_reg[i] == lru_rank)) begin
                lru_idx = IDX_W'(i);
            end
        end
    end

    assign hit = |acc_match;

    // Choose the target slot and the recency rank it leaves
    always_comb begin
        if (hit) begin
            tgt_idx  = hit_idx;
            old_rank = CNT_W'(rank_reg[hit_idx]);
            len_sel  = len_reg[hit_idx];
        end else if (free_slot) begin
            tgt_idx  = filled_reg[IDX_W-1:0];
            old_rank = filled_reg;
            len_sel  = fill_len;
        end else begin
            tgt_idx  = lru_idx;
            old_rank = filled_reg - CNT_W'(1);
            len_sel  = fill_len;
        end
    end

    // Bytes to copy: stored length past the offset, capped by the request
    always_comb begin
        copy_raw = (len_sel > 17'(boff)) ? (len_sel - 17'(boff)) : '0;
        if (in_reg.request_length < 32'(copy_raw)) begin
            copy_len = 17'(in_reg.request_length);
        end else begin
            copy_len = copy_raw;
        end
    end

    assign do_rename = (in_reg.func == lbc_pkg::FUNC_RENAME);
    assign do_access = (in_reg.func == lbc_pkg::FUNC_ACCESS)
                       && (in_reg.request_length != '0);
    assign miss_fail = do_access && !hit && in_reg.fill_failed;
    assign do_update = do_access && !miss_fail;

    // Next tag store contents
    always_comb begin
        filled_next = filled_reg;
        for (int i = 0; i < SLOTS; i++) begin
            file_next[i] = file_reg[i];
            bnum_next[i] = bnum_reg[i];
            len_next[i]  = len_reg[i];
            rank_next[i] = rank_reg[i];
            if (do_rename && ren_match[i]) begin
                file_next[i] = in_reg.new_file_id;
            end
            if (do_update) begin
                if (valid_vec[i] && (CNT_W'(rank_reg[i]) < old_rank)) begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
                if (tgt_idx == IDX_W'(i)) begin
                    rank_next[i] = '0;
                    if (!hit) begin
                        file_next[i] = in_reg.file_id;
                        bnum_next[i] = bnum;
                        len_next[i]  = fill_len;
                    end
                end
            end
        end
        if (do_update && !hit && free_slot) begin
            filled_next = filled_reg + CNT_W'(1);
        end
    end

    // Build the result beat
    always_comb begin
        out_next = '0;
        if (do_rename) begin
            out_next.renamed_count = 5'($countones(ren_match));
        end else if (miss_fail) begin
            out_next.block_offset = boff;
            out_next.status       = lbc_pkg::STATUS_FILL_FAILED;
        end else if (do_access) begin
            out_next.hit           = hit;
            out_next.slot          = 4'(tgt_idx);
            out_next.evicted       = !hit && !free_slot;
            out_next.block_offset  = boff;
            out_next.bytes_to_copy = copy_len;
            out_next.end_of_file   = len_sel < bs;
            out_next.status        = lbc_pkg::STATUS_OK;
        end
    end

    // Control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            filled_reg       <= '0;
            slots_in_use_reg <= lbc_pkg::SLOTS_IN_USE_RST;
            blk_log2_reg     <= lbc_pkg::BLOCK_SIZE_LOG2_RST;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                filled_reg    <= filled_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    lbc_pkg::CFG_SLOTS_IN_USE: begin
                        slots_in_use_reg <= cfg_wdata;
                    end
                    lbc_pkg::CFG_BLOCK_SIZE_LOG2: begin
                        blk_log2_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers and tag store
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (fire) begin
            out_reg <= out_next;
            for (int i = 0; i < SLOTS; i++) begin
                file_reg[i] <= file_next[i];
                bnum_reg[i] <= bnum_next[i];
                len_reg[i]  <= len_next[i];
                rank_reg[i] <= rank_next[i];
            end
        end
    end

endmodule
